// ===== src/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

    // field widths
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int CH_W    = 8;
    localparam int F_W     = 6;
    localparam int NUM_W   = 13;
    localparam int PROD_W  = 20;
    localparam int SCALE_W = 24;
    localparam int DIVN_W  = 18;
    localparam int RECIP_W = 19;
    localparam int QUOT_W  = DIVN_W + RECIP_W;
    localparam int TDATA_W = 24;

    // range limits and scale constants
    localparam logic [HUE_W-1:0] HUE_WRAP    = 9'd360;
    localparam logic [HUE_W-1:0] SECTOR_SPAN = 9'd60;
    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
    localparam logic [NUM_W-1:0] NUM_SCALE   = 13'd6000;
    localparam logic [NUM_W-1:0] LOW_FACTOR  = 13'd60;
    localparam logic [F_W-1:0]   F_SPAN      = 6'd60;

    // floor(x / 625) = (x * RECIP_MUL) >> RECIP_SHIFT for any 18-bit x
    localparam logic [RECIP_W-1:0] RECIP_MUL   = 19'd429497;
    localparam int                 RECIP_SHIFT = 28;
    // 255 / 600000 = 17 / (64 * 625)
    localparam int                 PRE_SHIFT   = 6;

    // hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } sector_t;

    // level lanes
    localparam int LEVELS = 4;
    typedef enum logic [1:0] {
        LVL_FULL,
        LVL_LOW,
        LVL_FALL,
        LVL_RISE
    } level_t;

endpackage

// ===== src/hsv_to_rgb_converter_core.sv =====
// hsv to rgb color converter, five register stages
// each color passes through every stage register in order; the last one drives the output
// throughput: one color per cycle; each stage holds its item while the next one is full
// the slowest stage is the reciprocal multiply that replaces the divide by 600000
// reset clears only the stage valid bits, payload registers are not reset
module hsv_to_rgb_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // hue [8:0], saturation [15:9], brightness [22:16], zero [23]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [23:0] m_axis_tdata
);

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: wrapped hue split into sector and offset
    hsv2rgb_pkg::sector_t                sector1_reg, sector1_next;
    logic [hsv2rgb_pkg::F_W-1:0]         f_reg, f_next;
    logic [hsv2rgb_pkg::PCT_W-1:0]       sat1_reg, sat1_next;
    logic [hsv2rgb_pkg::PCT_W-1:0]       val1_reg, val1_next;

    // stage 2: level numerators over 6000
    hsv2rgb_pkg::sector_t                sector2_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0]       val2_reg;
    logic [hsv2rgb_pkg::NUM_W-1:0]       num_reg  [hsv2rgb_pkg::LEVELS];
    logic [hsv2rgb_pkg::NUM_W-1:0]       num_next [hsv2rgb_pkg::LEVELS];

    // stage 3: value times numerator
    hsv2rgb_pkg::sector_t                sector3_reg;
    logic [hsv2rgb_pkg::PROD_W-1:0]      prod_reg  [hsv2rgb_pkg::LEVELS];
    logic [hsv2rgb_pkg::PROD_W-1:0]      prod_next [hsv2rgb_pkg::LEVELS];

    // stage 4: scaled levels
    hsv2rgb_pkg::sector_t                sector4_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]        lvl_reg  [hsv2rgb_pkg::LEVELS];
    logic [hsv2rgb_pkg::CH_W-1:0]        lvl_next [hsv2rgb_pkg::LEVELS];

    // stage 5: output register
    logic [hsv2rgb_pkg::TDATA_W-1:0]     out_reg, out_next;

    logic [hsv2rgb_pkg::HUE_W-1:0]       hue_in, hue_w;
    logic [hsv2rgb_pkg::PCT_W-1:0]       sat_in, val_in;
    logic [hsv2rgb_pkg::NUM_W-1:0]       sf, sg;
    logic [hsv2rgb_pkg::SCALE_W-1:0]     scaled [hsv2rgb_pkg::LEVELS];
    logic [hsv2rgb_pkg::QUOT_W-1:0]      quot   [hsv2rgb_pkg::LEVELS];
    logic [hsv2rgb_pkg::CH_W-1:0]        red, green, blue;

    // handshake: a stage takes new data when it is empty or its successor moves
    assign rdy5 = !v5_reg || m_axis_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = out_reg;

    assign v1_next = rdy1 ? s_axis_tvalid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;
    assign v5_next = rdy5 ? v4_reg : v5_reg;

    // input unpack, clamp and hue wrap
    assign hue_in = s_axis_tdata[8:0];
    assign sat_in = s_axis_tdata[15:9];
    assign val_in = s_axis_tdata[22:16];

    always_comb
    begin
        hue_w     = (hue_in >= hsv2rgb_pkg::HUE_WRAP) ? hue_in - hsv2rgb_pkg::HUE_WRAP : hue_in;
        sat1_next = (sat_in > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : sat_in;
        val1_next = (val_in > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : val_in;
    end

    // sector and offset by compare chain
    always_comb
    begin
        if (hue_w < hsv2rgb_pkg::SECTOR_SPAN)
        begin
            sector1_next = hsv2rgb_pkg::SEC_RED_YELLOW;
            f_next       = hue_w[hsv2rgb_pkg::F_W-1:0];
        end
        else if (hue_w < 9'(2 * hsv2rgb_pkg::SECTOR_SPAN))
        begin
            sector1_next = hsv2rgb_pkg::SEC_YELLOW_GREEN;
            f_next       = 6'(hue_w - 9'(hsv2rgb_pkg::SECTOR_SPAN));
        end
        else if (hue_w < 9'(3 * hsv2rgb_pkg::SECTOR_SPAN))
        begin
            sector1_next = hsv2rgb_pkg::SEC_GREEN_CYAN;
            f_next       = 6'(hue_w - 9'(2 * hsv2rgb_pkg::SECTOR_SPAN));
        end
        else if (hue_w < 9'(4 * hsv2rgb_pkg::SECTOR_SPAN))
        begin
            sector1_next = hsv2rgb_pkg::SEC_CYAN_BLUE;
            f_next       = 6'(hue_w - 9'(3 * hsv2rgb_pkg::SECTOR_SPAN));
        end
        else if (hue_w < 9'(5 * hsv2rgb_pkg::SECTOR_SPAN))
        begin
            sector1_next = hsv2rgb_pkg::SEC_BLUE_MAGENTA;
            f_next       = 6'(hue_w - 9'(4 * hsv2rgb_pkg::SECTOR_SPAN));
        end
        else
        begin
            sector1_next = hsv2rgb_pkg::SEC_MAGENTA_RED;
            f_next       = 6'(hue_w - 9'(5 * hsv2rgb_pkg::SECTOR_SPAN));
        end
    end

    // numerators, all levels over a common 6000 denominator
    always_comb
    begin
        sf = hsv2rgb_pkg::NUM_W'(sat1_reg) * hsv2rgb_pkg::NUM_W'(f_reg);
        sg = hsv2rgb_pkg::NUM_W'(sat1_reg)
           * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::F_SPAN - f_reg);
        num_next[hsv2rgb_pkg::LVL_FULL] = hsv2rgb_pkg::NUM_SCALE;
        num_next[hsv2rgb_pkg::LVL_LOW]  =
            hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::PCT_MAX - sat1_reg) * hsv2rgb_pkg::LOW_FACTOR;
        num_next[hsv2rgb_pkg::LVL_FALL] = hsv2rgb_pkg::NUM_SCALE - sf;
        num_next[hsv2rgb_pkg::LVL_RISE] = hsv2rgb_pkg::NUM_SCALE - sg;
    end

    // per-lane multiply and constant divide
    always_comb
    begin
        for (int i = 0; i < hsv2rgb_pkg::LEVELS; i++)
        begin
            prod_next[i] = hsv2rgb_pkg::PROD_W'(val2_reg) * hsv2rgb_pkg::PROD_W'(num_reg[i]);
            scaled[i]    = {prod_reg[i], 4'b0000} + hsv2rgb_pkg::SCALE_W'(prod_reg[i]);
            quot[i]      = hsv2rgb_pkg::QUOT_W'(
                               scaled[i][hsv2rgb_pkg::SCALE_W-1:hsv2rgb_pkg::PRE_SHIFT])
                         * hsv2rgb_pkg::QUOT_W'(hsv2rgb_pkg::RECIP_MUL);
            lvl_next[i]  = quot[i][hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CH_W];
        end
    end

    // level to channel assignment per sector
    always_comb
    begin
        case (sector4_reg)
            hsv2rgb_pkg::SEC_RED_YELLOW:
            begin
                red   = lvl_reg[hsv2rgb_pkg::LVL_FULL];
                green = lvl_reg[hsv2rgb_pkg::LVL_RISE];
                blue  = lvl_reg[hsv2rgb_pkg::LVL_LOW];
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN:
            begin
                red   = lvl_reg[hsv2rgb_pkg::LVL_FALL];
                green = lvl_reg[hsv2rgb_pkg::LVL_FULL];
                blue  = lvl_reg[hsv2rgb_pkg::LVL_LOW];
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN:
            begin
                red   = lvl_reg[hsv2rgb_pkg::LVL_LOW];
                green = lvl_reg[hsv2rgb_pkg::LVL_FULL];
                blue  = lvl_reg[hsv2rgb_pkg::LVL_RISE];
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE:
            begin
                red   = lvl_reg[hsv2rgb_pkg::LVL_LOW];
                green = lvl_reg[hsv2rgb_pkg::LVL_FALL];
                blue  = lvl_reg[hsv2rgb_pkg::LVL_FULL];
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA:
            begin
                red   = lvl_reg[hsv2rgb_pkg::LVL_RISE];
                green = lvl_reg[hsv2rgb_pkg::LVL_LOW];
                blue  = lvl_reg[hsv2rgb_pkg::LVL_FULL];
            end
            default:
            begin
                red   = lvl_reg[hsv2rgb_pkg::LVL_FULL];
                green = lvl_reg[hsv2rgb_pkg::LVL_LOW];
                blue  = lvl_reg[hsv2rgb_pkg::LVL_FALL];
            end
        endcase
        out_next = {blue, green, red};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            sector1_reg <= sector1_next;
            f_reg       <= f_next;
            sat1_reg    <= sat1_next;
            val1_reg    <= val1_next;
        end
        if (rdy2)
        begin
            sector2_reg <= sector1_reg;
            val2_reg    <= val1_reg;
            num_reg     <= num_next;
        end
        if (rdy3)
        begin
            sector3_reg <= sector2_reg;
            prod_reg    <= prod_next;
        end
        if (rdy4)
        begin
            sector4_reg <= sector3_reg;
            lvl_reg     <= lvl_next;
        end
        if (rdy5)
        begin
            out_reg <= out_next;
        end
    end

endmodule
